// File: src/ppa_pkg.sv
// Shared types, constants and request codes of the port pair allocator.
// The bitmap is held as WORD_W-bit words; every module imports this package.
// No dependencies.
`timescale 1ns / 1ps

package ppa_pkg;

    // Port numbering and bitmap geometry
    localparam int PORT_SPACE = 65536;
    localparam int PORT_W     = 16;
    localparam int WORD_W     = 64;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORD_CNT   = PORT_SPACE / WORD_W;
    localparam int ADDR_W     = $clog2(WORD_CNT);

    localparam logic [PORT_W-1:0] PORT_MAX = PORT_W'(PORT_SPACE - 1);

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST  = CFG_IDX_W'(1);
    localparam logic [PORT_W-1:0] RANGE_FIRST_RST = PORT_W'(30000);
    localparam logic [PORT_W-1:0] RANGE_LAST_RST  = PORT_W'(40000);

    // Request kinds
    localparam logic [1:0] KIND_GET_ONE      = 2'd0;
    localparam logic [1:0] KIND_GET_PAIR     = 2'd1;
    localparam logic [1:0] KIND_RELEASE_ONE  = 2'd2;
    localparam logic [1:0] KIND_RELEASE_PAIR = 2'd3;

    // Result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PORT_W-1:0] port_a;
        logic [PORT_W-1:0] port_b;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [PORT_W-1:0] got_first;
        logic [PORT_W-1:0] got_second;
    } t_rsp;

    // One read and one write per cycle on the bitmap store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_mem_cmd;

    // What the word evaluator needs to know about the word under test
    typedef struct packed {
        logic              pair;
        logic [ADDR_W-1:0] word_addr;
        logic [PORT_W-1:0] first;
        logic [PORT_W-1:0] last;
    } t_eval_ctx;

    typedef struct packed {
        logic              found;
        logic [BIT_W-1:0]  bit_idx;
        logic [WORD_W-1:0] new_word;
    } t_eval_res;

endpackage

// File: src/ppa_map_store.sv
// Bitmap store of used ports: WORD_CNT words, one synchronous read port and one write port.
// Runs a clearing pass after reset. Depends on ppa_pkg.
`timescale 1ns / 1ps

module ppa_map_store
    import ppa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_cmd          i_cmd,
    output logic [WORD_W-1:0] o_rd_data,
    output logic              o_clearing
);

    logic [WORD_W-1:0] r_mem [WORD_CNT];
    logic [WORD_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clearing;

    // Clearing pass: one word per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(WORD_CNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Write port: the clearing pass has the port until it is done
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
    end

    // Read port with registered data
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// File: src/ppa_word_eval.sv
// Evaluates one bitmap word: masks it to the port range, finds the lowest free port
// or even-aligned free pair, and builds the word with those ports marked. Depends on ppa_pkg.
`timescale 1ns / 1ps

module ppa_word_eval
    import ppa_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  t_eval_ctx         i_ctx,
    output t_eval_res         o_res
);

    // Index of the lowest set bit; zero when none is set
    function automatic logic [BIT_W-1:0] f_lowest(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] pair_bits;
    logic [WORD_W-1:0] cand;
    logic [BIT_W-1:0]  idx;
    logic [WORD_W-1:0] set_mask;

    // Range masks apply only in the first and last word of the range
    always_comb begin
        lo_mask = '1;
        hi_mask = '1;
        if (i_ctx.word_addr == i_ctx.first[BIT_W +: ADDR_W]) begin
            lo_mask = {WORD_W{1'b1}} << i_ctx.first[BIT_W-1:0];
        end
        if (i_ctx.word_addr == i_ctx.last[BIT_W +: ADDR_W]) begin
            hi_mask = {WORD_W{1'b1}} >> (~i_ctx.last[BIT_W-1:0]);
        end
        free_bits = ~i_word & lo_mask & hi_mask;
    end

    // A pair candidate sits on its even bit; pairs never cross a word
    always_comb begin
        pair_bits = '0;
        for (int k = 0; k < WORD_W / 2; k++) begin
            pair_bits[2*k] = free_bits[2*k] & free_bits[2*k+1];
        end
    end

    always_comb begin
        cand     = i_ctx.pair ? pair_bits : free_bits;
        idx      = f_lowest(cand);
        set_mask = WORD_W'(1) << idx;
        if (i_ctx.pair) begin
            set_mask = set_mask | (WORD_W'(2) << idx);
        end
        o_res.found    = |cand;
        o_res.bit_idx  = idx;
        o_res.new_word = i_word | set_mask;
    end

endmodule

// File: src/ppa_ctrl.sv
// Request sequencer: scans the bitmap word by word for gets and does read-modify-write
// for releases, then issues one result. Depends on ppa_pkg.
`timescale 1ns / 1ps

module ppa_ctrl
    import ppa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_req              i_req,
    input  logic [PORT_W-1:0] i_first,
    input  logic [PORT_W-1:0] i_last,
    input  logic              i_clearing,
    input  logic [WORD_W-1:0] i_rd_data,
    input  t_eval_res         i_eval,
    output t_eval_ctx         o_ctx,
    output t_mem_cmd          o_cmd,
    output logic              o_busy,
    output logic              o_done,
    output t_rsp              o_rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REL_A,
        ST_REL_B_RD,
        ST_REL_B
    } t_state;

    t_state            r_state;
    logic              r_busy;
    logic              r_done;
    t_rsp              r_rsp;
    t_req              r_req;
    logic              r_pair;
    logic [ADDR_W-1:0] r_addr;
    logic [PORT_W-1:0] r_last_eff;

    logic              accept;
    logic              is_get;
    logic [PORT_W-1:0] last_eff;
    logic              range_empty;
    logic [ADDR_W-1:0] last_word;
    logic [PORT_W-1:0] got_port;
    logic              pa_valid;
    logic              pb_valid;

    assign o_busy = r_busy | i_clearing;
    assign accept = i_start & ~o_busy;
    assign is_get = (i_req.kind == KIND_GET_ONE) || (i_req.kind == KIND_GET_PAIR);

    // Clip the range to the port space and detect an empty range
    always_comb begin
        last_eff    = (i_last > PORT_MAX) ? PORT_MAX : i_last;
        range_empty = i_first > last_eff;
    end

    assign last_word = r_last_eff[BIT_W +: ADDR_W];
    assign got_port  = PORT_W'({r_addr, i_eval.bit_idx});
    assign pa_valid  = r_req.port_a <= PORT_MAX;
    assign pb_valid  = r_req.port_b <= PORT_MAX;

    assign o_ctx.pair      = r_pair;
    assign o_ctx.word_addr = r_addr;
    assign o_ctx.first     = i_first;
    assign o_ctx.last      = r_last_eff;

    // Memory commands for each step
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.rd_en = is_get ? ~range_empty : 1'b1;
                    o_cmd.rd_addr = is_get ? i_first[BIT_W +: ADDR_W]
                                           : i_req.port_a[BIT_W +: ADDR_W];
                end
            end
            ST_SCAN: begin
                if (i_eval.found) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = r_addr;
                    o_cmd.wr_data = i_eval.new_word;
                end else if (r_addr != last_word) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = r_addr + ADDR_W'(1);
                end
            end
            ST_REL_A: begin
                o_cmd.wr_en   = pa_valid;
                o_cmd.wr_addr = r_req.port_a[BIT_W +: ADDR_W];
                o_cmd.wr_data = i_rd_data & ~(WORD_W'(1) << r_req.port_a[BIT_W-1:0]);
            end
            ST_REL_B_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_req.port_b[BIT_W +: ADDR_W];
            end
            ST_REL_B: begin
                o_cmd.wr_en   = pb_valid;
                o_cmd.wr_addr = r_req.port_b[BIT_W +: ADDR_W];
                o_cmd.wr_data = i_rd_data & ~(WORD_W'(1) << r_req.port_b[BIT_W-1:0]);
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // State, working registers and the registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_req      <= i_req;
                        r_pair     <= i_req.kind == KIND_GET_PAIR;
                        r_last_eff <= last_eff;
                        if (is_get) begin
                            r_addr <= i_first[BIT_W +: ADDR_W];
                            if (range_empty) begin
                                r_done <= 1'b1;
                                r_rsp  <= '{STATUS_NOT_FOUND, '0, '0};
                            end else begin
                                r_busy  <= 1'b1;
                                r_state <= ST_SCAN;
                            end
                        end else begin
                            r_busy  <= 1'b1;
                            r_state <= ST_REL_A;
                        end
                    end
                end
                ST_SCAN: begin
                    if (i_eval.found) begin
                        r_done  <= 1'b1;
                        r_rsp   <= '{STATUS_OK, got_port,
                                     r_pair ? got_port + PORT_W'(1) : '0};
                        r_busy  <= 1'b0;
                        r_state <= ST_IDLE;
                    end else if (r_addr == last_word) begin
                        r_done  <= 1'b1;
                        r_rsp   <= '{STATUS_NOT_FOUND, '0, '0};
                        r_busy  <= 1'b0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                ST_REL_A: begin
                    if (r_req.kind == KIND_RELEASE_PAIR) begin
                        r_state <= ST_REL_B_RD;
                    end else begin
                        r_done  <= 1'b1;
                        r_rsp   <= '{STATUS_OK, '0, '0};
                        r_busy  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_REL_B_RD: begin
                    r_state <= ST_REL_B;
                end
                ST_REL_B: begin
                    r_done  <= 1'b1;
                    r_rsp   <= '{STATUS_OK, '0, '0};
                    r_busy  <= 1'b0;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// File: src/port_pair_allocator.sv
// Top level of the port pair allocator: range registers, sequencer, word evaluator
// and bitmap store. Depends on ppa_pkg, ppa_map_store, ppa_word_eval and ppa_ctrl.
//
//   Channel   Direction  Handshake                   Payload
//   request   in         i_start & ~o_busy           i_req  (t_req)
//   result    out        o_done, one cycle, no stall o_rsp  (t_rsp)
//   config    in         i_cfg_valid & o_cfg_ready   i_cfg_index, i_cfg_data
//
// After reset the bitmap is cleared one word per cycle, all WORD_CNT (1024) words, with
// o_busy high; configuration writes are taken during that time.
// A get reads one 64-port word at a time, from the word of range_first through
// the hit word (or the word of range_last); a get on an empty range reads no word.
// A release of one port is one read-modify-write, a release of a pair two.
// The result is held for one cycle only; the receiver cannot stall it.
`timescale 1ns / 1ps

module port_pair_allocator
    import ppa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_req                 i_req,
    output logic                 o_busy,
    output logic                 o_done,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PORT_W-1:0]    i_cfg_data
);

    logic [PORT_W-1:0] r_range_first;
    logic [PORT_W-1:0] r_range_last;

    t_mem_cmd          mem_cmd;
    logic [WORD_W-1:0] rd_data;
    logic              clearing;
    t_eval_ctx         eval_ctx;
    t_eval_res         eval_res;

    assign o_cfg_ready = 1'b1;

    // Range registers; writes to other indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_first <= RANGE_FIRST_RST;
            r_range_last  <= RANGE_LAST_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_RANGE_FIRST) begin
                r_range_first <= i_cfg_data;
            end
            if (i_cfg_index == CFG_RANGE_LAST) begin
                r_range_last <= i_cfg_data;
            end
        end
    end

    ppa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req      (i_req),
        .i_first    (r_range_first),
        .i_last     (r_range_last),
        .i_clearing (clearing),
        .i_rd_data  (rd_data),
        .i_eval     (eval_res),
        .o_ctx      (eval_ctx),
        .o_cmd      (mem_cmd),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

    ppa_word_eval u_eval (
        .i_word (rd_data),
        .i_ctx  (eval_ctx),
        .o_res  (eval_res)
    );

    ppa_map_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (mem_cmd),
        .o_rd_data  (rd_data),
        .o_clearing (clearing)
    );

endmodule

// File: tb/ppa_checker.sv
// Checker for the port pair allocator: watches the request, result and config channels,
// keeps its own copy of the range registers and the port bitmap, and compares results.
// Depends on ppa_pkg.
`timescale 1ns / 1ps

module ppa_checker
    import ppa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_req                 i_req,
    input  logic                 i_busy,
    input  logic                 i_done,
    input  t_rsp                 i_rsp,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PORT_W-1:0]    i_cfg_data,
    output int                   o_fail_cnt,
    output int                   o_pending
);

    // Mirror of the allocator state
    bit                port_used [PORT_SPACE];
    logic [PORT_W-1:0] window_first;
    logic [PORT_W-1:0] window_last;

    t_rsp expected_rsp_q[$];
    int   fail_total;

    initial begin
        fail_total = 0;
    end

    // Works out the result of one request and applies its effect on the bitmap.
    function automatic t_rsp predict_alloc(input t_req req);
        t_rsp rsp;
        int   lo;
        int   hi;
        rsp = '0;
        lo  = int'(window_first);
        hi  = int'(window_last);
        case (req.kind)
            KIND_GET_ONE: begin
                rsp.status = STATUS_NOT_FOUND;
                for (int p = lo; p <= hi; p++) begin
                    if (!port_used[p]) begin
                        port_used[p]  = 1'b1;
                        rsp.status    = STATUS_OK;
                        rsp.got_first = PORT_W'(p);
                        break;
                    end
                end
            end
            KIND_GET_PAIR: begin
                rsp.status = STATUS_NOT_FOUND;
                // The odd partner must itself lie inside the window.
                for (int p = lo; p < hi; p++) begin
                    if (p % 2 == 0 && !port_used[p] && !port_used[p + 1]) begin
                        port_used[p]     = 1'b1;
                        port_used[p + 1] = 1'b1;
                        rsp.status       = STATUS_OK;
                        rsp.got_first    = PORT_W'(p);
                        rsp.got_second   = PORT_W'(p + 1);
                        break;
                    end
                end
            end
            KIND_RELEASE_ONE: begin
                port_used[req.port_a] = 1'b0;
            end
            default: begin
                port_used[req.port_a] = 1'b0;
                port_used[req.port_b] = 1'b0;
            end
        endcase
        return rsp;
    endfunction

    // All channels are sampled at the rising edge; outputs are updated after it.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            foreach (port_used[i]) port_used[i] = 1'b0;
            window_first = RANGE_FIRST_RST;
            window_last  = RANGE_LAST_RST;
            expected_rsp_q.delete();
        end else begin
            // A result transfer is matched against the oldest request still open.
            if (i_done) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_total++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (i_rsp.status !== exp_rsp.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_rsp.status, i_rsp.status);
                        fail_total++;
                    end
                    if (i_rsp.got_first !== exp_rsp.got_first) begin
                        $error("got_first: expected %0d, actual %0d",
                               exp_rsp.got_first, i_rsp.got_first);
                        fail_total++;
                    end
                    if (i_rsp.got_second !== exp_rsp.got_second) begin
                        $error("got_second: expected %0d, actual %0d",
                               exp_rsp.got_second, i_rsp.got_second);
                        fail_total++;
                    end
                end
            end

            // Register writes; indexes beyond the two registers are ignored.
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_RANGE_FIRST) window_first = i_cfg_data;
                else if (i_cfg_index == CFG_RANGE_LAST) window_last = i_cfg_data;
            end

            if (i_start && !i_busy) expected_rsp_q.push_back(predict_alloc(i_req));
        end
        o_pending  <= expected_rsp_q.size();
        o_fail_cnt <= fail_total;
    end

endmodule

// File: tb/tb_port_pair_allocator.sv
// Testbench top for the port pair allocator: clock, reset, request and config stimulus,
// watchdog and final verdict. Depends on ppa_pkg, port_pair_allocator and ppa_checker.
`timescale 1ns / 1ps

module tb_port_pair_allocator;
    import ppa_pkg::*;

    localparam int ITEM_TARGET    = 1750;
    localparam int QUIET_TAIL     = 200;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 20;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(3);

    logic                 clk;
    logic                 rst_n;
    logic                 req_start;
    t_req                 req;
    logic                 busy;
    logic                 done;
    t_rsp                 rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PORT_W-1:0]    cfg_data;
    int                   fail_cnt;
    int                   pending;
    int                   idle_cycles;
    int                   sent;

    port_pair_allocator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (req_start),
        .i_req       (req),
        .o_busy      (busy),
        .o_done      (done),
        .o_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ppa_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (req_start),
        .i_req       (req),
        .i_busy      (busy),
        .i_done      (done),
        .i_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (req_start && !busy) || done || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one request and returns at the edge that transfers it; start stays high.
    task automatic send_req(input logic [1:0] kind, input logic [PORT_W-1:0] port_a,
                            input logic [PORT_W-1:0] port_b);
        req_start <= 1'b1;
        req       <= '{kind: kind, port_a: port_a, port_b: port_b};
        do @(posedge clk); while (busy);
        sent++;
    endtask

    // Stops requests and waits until every result is back and the block is idle.
    task automatic wait_idle();
        req_start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [PORT_W-1:0] data,
                             input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (!hold) cfg_valid <= 1'b0;
    endtask

    task automatic set_window(input int lo, input int hi);
        wait_idle();
        write_cfg(CFG_RANGE_FIRST, PORT_W'(lo), 1'b1);
        write_cfg(CFG_RANGE_LAST, PORT_W'(hi), 1'b0);
    endtask

    // Mostly narrow windows so gets run out; at times empty or at the port space edges.
    task automatic pick_window(output int lo, output int hi);
        case ($urandom_range(0, 9))
            0: begin
                lo = 0;
                hi = PORT_SPACE - 1;
            end
            1: begin
                lo = $urandom_range(1, PORT_SPACE - 1);
                hi = lo - 1;
            end
            2: begin
                hi = PORT_SPACE - 1;
                lo = hi - $urandom_range(0, 64);
            end
            3: begin
                lo = 0;
                hi = $urandom_range(0, 64);
            end
            default: begin
                lo = $urandom_range(0, PORT_SPACE - 1 - 150);
                hi = lo + $urandom_range(0, 150);
            end
        endcase
    endtask

    initial begin
        int lo;
        int hi;
        int span;
        int phase_len;
        int pick;
        bit gaps_on;
        logic [1:0]        kind;
        logic [PORT_W-1:0] port_a;
        logic [PORT_W-1:0] port_b;

        sent = 0;
        rst_n     <= 1'b0;
        req_start <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_RANGE_FIRST;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset window, reuse of released ports, releases outside the window.
        send_req(KIND_GET_ONE, 16'h0000, 16'h0000);
        send_req(KIND_GET_PAIR, 16'h0000, 16'h0000);
        send_req(KIND_GET_ONE, 16'h0000, 16'h0000);
        send_req(KIND_RELEASE_ONE, 16'd30000, 16'hFFFF);
        send_req(KIND_GET_PAIR, 16'hFFFF, 16'hFFFF);
        send_req(KIND_RELEASE_PAIR, 16'd30002, 16'd30003);
        send_req(KIND_RELEASE_ONE, 16'hFFFF, 16'h0000);
        send_req(KIND_RELEASE_PAIR, 16'h0000, 16'hFFFF);
        send_req(KIND_GET_ONE, 16'h0000, 16'h0000);

        // Directed: window at the top of the port space until it is exhausted.
        set_window(PORT_SPACE - 2, PORT_SPACE - 1);
        send_req(KIND_GET_PAIR, 16'h0000, 16'h0000);
        send_req(KIND_GET_ONE, 16'h0000, 16'h0000);
        send_req(KIND_GET_PAIR, 16'h0000, 16'h0000);
        send_req(KIND_RELEASE_PAIR, 16'hFFFE, 16'hFFFF);
        send_req(KIND_GET_ONE, 16'h0000, 16'h0000);
        send_req(KIND_GET_ONE, 16'h0000, 16'h0000);
        send_req(KIND_GET_ONE, 16'h0000, 16'h0000);
        send_req(KIND_RELEASE_PAIR, 16'hFFFF, 16'hFFFE);

        // Directed: empty window finds nothing.
        set_window(100, 99);
        send_req(KIND_GET_ONE, 16'h0000, 16'h0000);
        send_req(KIND_GET_PAIR, 16'h0000, 16'h0000);

        // Directed: the only even port is the window end, so no pair fits.
        set_window(7, 8);
        send_req(KIND_GET_PAIR, 16'h0000, 16'h0000);
        send_req(KIND_GET_ONE, 16'h0000, 16'h0000);

        // Directed: write to an unused index, then a single-port window at zero.
        wait_idle();
        write_cfg(CFG_IDX_SPARE, 16'hFFFF, 1'b0);
        set_window(0, 0);
        send_req(KIND_GET_ONE, 16'h0000, 16'h0000);
        send_req(KIND_GET_PAIR, 16'h0000, 16'h0000);
        send_req(KIND_RELEASE_ONE, 16'h0000, 16'h0000);

        // Random phases: a new window, then a mix of gets and releases around it.
        while (sent < ITEM_TARGET) begin
            pick_window(lo, hi);
            set_window(lo, hi);
            span      = (hi >= lo) ? hi - lo : 0;
            gaps_on   = (sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 9) < 7);
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) begin
                if (gaps_on && sent < ITEM_TARGET - QUIET_TAIL &&
                    $urandom_range(0, 3) == 0) begin
                    req_start <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 30) kind = KIND_GET_ONE;
                else if (pick < 55) kind = KIND_GET_PAIR;
                else if (pick < 80) kind = KIND_RELEASE_ONE;
                else kind = KIND_RELEASE_PAIR;
                // Releases mostly hit the window and its borders, sometimes anywhere.
                if ($urandom_range(0, 99) < 85) begin
                    port_a = PORT_W'(lo - 2 + $urandom_range(0, span + 4));
                end else begin
                    port_a = PORT_W'($urandom_range(0, PORT_SPACE - 1));
                end
                if ($urandom_range(0, 99) < 80) port_b = port_a + 1'b1;
                else port_b = PORT_W'($urandom_range(0, PORT_SPACE - 1));
                send_req(kind, port_a, port_b);
            end
        end

        // Drain and verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
